[hw/rtl/assert_macros.svh]
// Assertion macros shared by the line assembler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ACLA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition implies another in the same cycle.
`define ACLA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define ACLA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/acla_pkg.sv]
// Shared types, constants and helpers of the command line assembler.
package acla_pkg;

   localparam int LINE_BYTES  = 64;
   localparam int CHAR_W      = 7;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_BS  = 8'h08;
   localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
   localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;
   localparam logic [BYTE_W-1:0] BYTE_DEL = 8'h7F;
   localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

   localparam logic [CHAR_W-1:0] CH_A    = 7'h41;
   localparam logic [CHAR_W-1:0] CH_T    = 7'h54;
   localparam logic [CHAR_W-1:0] CH_Z    = 7'h5A;
   localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CH_NINE = 7'h39;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CHAR,
      OP_BKSP,
      OP_EOL,
      OP_FRAME_END
   } op_code_type;

   typedef struct packed {
      op_code_type       code;
      logic [CHAR_W-1:0] ch;
   } op_type;

   function automatic logic is_upper_or_digit(input logic [CHAR_W-1:0] ch);
      return ((ch >= CH_A) && (ch <= CH_Z)) || ((ch >= CH_ZERO) && (ch <= CH_NINE));
   endfunction

endpackage

[hw/rtl/acla_front.sv]
// Front end: accepts request beats, classifies bytes and pushes operations.
module acla_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_command,
   input  logic [acla_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                       push,
   output acla_pkg::op_type           push_op,
   input  logic                       queue_ready
);
   import acla_pkg::*;

   logic   valid_ff, valid_in;
   op_type op_ff, op_in;
   op_type op_class;
   logic   take;

   always_comb begin
      op_class.ch = req_rx_byte[CHAR_W-1:0];
      priority if (req_command) begin
         op_class.code = OP_FRAME_END;
      end else if ((req_rx_byte == BYTE_CR) || (req_rx_byte == BYTE_LF)) begin
         op_class.code = OP_EOL;
      end else if ((req_rx_byte == BYTE_BS) || (req_rx_byte == BYTE_DEL)) begin
         op_class.code = OP_BKSP;
      end else if ((req_rx_byte < PRINT_LO) || (req_rx_byte > PRINT_HI)) begin
         // NUL, other control bytes and bytes above the printable range
         op_class.code = OP_NONE;
      end else begin
         op_class.code = OP_CHAR;
      end
   end

   assign req_stall = valid_ff && !queue_ready;
   assign take      = req_valid && !req_stall;
   assign push      = valid_ff && queue_ready;
   assign push_op   = op_ff;

   always_comb begin
      valid_in = valid_ff && !queue_ready;
      op_in    = op_ff;
      if (take) begin
         // drop bytes that change nothing
         valid_in = (op_class.code != OP_NONE);
         op_in    = op_class;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      op_ff <= op_in;
   end

endmodule

[hw/rtl/acla_queue.sv]
// Short operation queue between the front end and the line engine.
`include "assert_macros.svh"

module acla_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  acla_pkg::op_type push_op,
   output logic             ready,
   output logic             head_valid,
   output acla_pkg::op_type head_op,
   input  logic             pop
);
   import acla_pkg::*;

   op_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  head_ff, head_in;
   logic [QUEUE_AW-1:0]  tail_ff, tail_in;
   logic [QUEUE_CW-1:0]  count_ff, count_in;

   assign ready      = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = entries_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = QUEUE_AW'((32'(tail_ff) + 1) % QUEUE_DEPTH);
      end
      if (pop) begin
         head_in = QUEUE_AW'((32'(head_ff) + 1) % QUEUE_DEPTH);
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         entries_ff[tail_ff] <= push_op;
      end
   end

   `ACLA_ASSERT_IMP(a_queue_pop_nonempty, pop, count_ff != '0, "pop from empty op queue")

endmodule

[hw/rtl/acla_back.sv]
// Line engine: keeps the line store, applies operations and emits lines.
`include "assert_macros.svh"

module acla_back #(
   parameter int LINE_BYTES = acla_pkg::LINE_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  acla_pkg::op_type            head_op,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [acla_pkg::CHAR_W-1:0] rsp_line_char,
   output logic                        rsp_last_of_line,
   output logic [acla_pkg::LEN_W-1:0]  rsp_line_length
);
   import acla_pkg::*;

   localparam int STORE_DEPTH = LINE_BYTES - 1;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int FILL_W      = $clog2(LINE_BYTES);
   localparam logic [FILL_W-1:0] STORE_CAP = FILL_W'(LINE_BYTES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_LAST,
      ST_CHK_PREV,
      ST_CHK_LONE,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_SET_T
   } state_type;

   logic [CHAR_W-1:0] store_mem [STORE_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [CHAR_W-1:0] wr_data;

   state_type         state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] cnt_ff, cnt_in;
   logic [FILL_W-1:0] len_ff, len_in;
   logic              split_ff, split_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_char    = rsp_char_ff;
   assign rsp_last_of_line = rsp_last_ff;
   assign rsp_line_length  = rsp_len_ff;
   assign out_free         = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      split_in     = split_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_len_in   = rsp_len_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(fill_ff);
      wr_data      = ch_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop   = 1'b1;
               ch_in = head_op.ch;
               unique case (head_op.code)
                  OP_BKSP: begin
                     if (fill_ff != '0) begin
                        fill_in = fill_ff - 1'b1;
                     end
                  end
                  OP_EOL: begin
                     if (fill_ff != '0) begin
                        len_in   = fill_ff;
                        cnt_in   = '0;
                        split_in = 1'b0;
                        state_in = ST_EMIT_RD;
                     end
                  end
                  OP_FRAME_END: begin
                     if (fill_ff == FILL_W'(1)) begin
                        // a lone 'A' may still become "AT"
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ST_CHK_LONE;
                     end else if (fill_ff != '0) begin
                        len_in   = fill_ff;
                        cnt_in   = '0;
                        split_in = 1'b0;
                        state_in = ST_EMIT_RD;
                     end
                  end
                  OP_CHAR: begin
                     if ((head_op.ch == CH_T) && (fill_ff >= FILL_W'(2))) begin
                        rd_en    = 1'b1;
                        rd_addr  = ADDR_W'(fill_ff - 1'b1);
                        state_in = ST_CHK_LAST;
                     end else if (fill_ff < STORE_CAP) begin
                        wr_en   = 1'b1;
                        wr_data = head_op.ch;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CHK_LAST: begin
            if (rd_data_ff == CH_A) begin
               rd_en    = 1'b1;
               rd_addr  = ADDR_W'(fill_ff - FILL_W'(2));
               state_in = ST_CHK_PREV;
            end else begin
               if (fill_ff < STORE_CAP) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_CHK_PREV: begin
            if (is_upper_or_digit(rd_data_ff)) begin
               if (fill_ff < STORE_CAP) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               // emit the text ahead of the 'A', then restart with "AT"
               len_in   = fill_ff - 1'b1;
               cnt_in   = '0;
               split_in = 1'b1;
               state_in = ST_EMIT_RD;
            end
         end
         ST_CHK_LONE: begin
            if (rd_data_ff == CH_A) begin
               state_in = ST_IDLE;
            end else begin
               len_in   = fill_ff;
               cnt_in   = '0;
               split_in = 1'b0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(cnt_ff);
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = rd_data_ff;
               rsp_last_in  = (cnt_ff == len_ff - 1'b1);
               rsp_len_in   = LEN_W'(len_ff);
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == len_ff - 1'b1) begin
                  if (split_ff) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = CH_A;
                     state_in = ST_SET_T;
                  end else begin
                     fill_in  = '0;
                     state_in = ST_IDLE;
                  end
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_SET_T: begin
            wr_en    = 1'b1;
            wr_addr  = ADDR_W'(1);
            wr_data  = CH_T;
            fill_in  = FILL_W'(2);
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      len_ff      <= len_in;
      split_ff    <= split_in;
      ch_ff       <= ch_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_len_ff  <= rsp_len_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   `ACLA_ASSERT(a_fill_in_range, fill_ff <= STORE_CAP, "fill count beyond store capacity")
   `ACLA_ASSERT_IMP(a_emit_in_line, state_ff == ST_EMIT_OUT, cnt_ff < len_ff, "emit index past line end")
   `ACLA_ASSERT_NEXT(a_split_restart, state_ff == ST_SET_T, fill_ff == FILL_W'(2), "store not left holding AT")
   `ACLA_ASSERT_IMP(a_pop_when_idle, pop, (state_ff == ST_IDLE) && head_valid, "op taken while busy")

endmodule

[hw/rtl/at_command_line_assembler.sv]
// Top level of the command line assembler: front end, op queue and line engine.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_stall  | req_command, req_rx_byte
//   rsp     | out | rsp_valid/rsp_stall  | rsp_line_char, rsp_last_of_line, rsp_line_length
//
// A byte is registered in the front end and queued; the line engine reads the line store
// for it only where the "AT" split check needs earlier characters.
// Each character of a line needs one store read and one output register load;
// after a split, "AT" is rewritten into the store once the line has left.
// Reset clears the fill count, the queue and all valid flags; the store needs no clearing.
// rsp_stall holds the line engine; the four-entry queue keeps taking bytes until full.
module at_command_line_assembler #(
   parameter int LINE_BYTES = acla_pkg::LINE_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  logic [acla_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [acla_pkg::CHAR_W-1:0] rsp_line_char,
   output logic                        rsp_last_of_line,
   output logic [acla_pkg::LEN_W-1:0]  rsp_line_length
);
   import acla_pkg::*;

   logic   push, queue_ready, head_valid, pop;
   op_type push_op, head_op;

   acla_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_rx_byte (req_rx_byte),
      .push        (push),
      .push_op     (push_op),
      .queue_ready (queue_ready)
   );

   acla_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .ready      (queue_ready),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop)
   );

   acla_back #(
      .LINE_BYTES (LINE_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_op          (head_op),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_char    (rsp_line_char),
      .rsp_last_of_line (rsp_last_of_line),
      .rsp_line_length  (rsp_line_length)
   );

endmodule

[dv/line_assembly_checker.sv]
`timescale 1ns / 100ps
// Line assembler checker: watches both channels, predicts emitted lines and compares each beat.
module line_assembly_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_command,
   input  logic [acla_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [acla_pkg::CHAR_W-1:0] rsp_line_char,
   input  logic                        rsp_last_of_line,
   input  logic [acla_pkg::LEN_W-1:0]  rsp_line_length,
   output int                          mismatches,
   output int                          chars_owed
);
   import acla_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic [LEN_W-1:0]  len;
   } line_beat_type;

   logic [CHAR_W-1:0] line_text [LINE_BYTES];
   int unsigned       text_fill;
   line_beat_type     owed_beats [$];

   function automatic op_code_type decode_req(input logic cmd, input logic [BYTE_W-1:0] rx);
      if (cmd) return OP_FRAME_END;
      if (rx == BYTE_CR || rx == BYTE_LF) return OP_EOL;
      if (rx == BYTE_BS || rx == BYTE_DEL) return OP_BKSP;
      // NUL and every other control or high byte falls out here
      if (rx < PRINT_LO || rx > PRINT_HI) return OP_NONE;
      return OP_CHAR;
   endfunction

   function automatic logic word_char(input logic [CHAR_W-1:0] c);
      return (c >= CH_A && c <= CH_Z) || (c >= CH_ZERO && c <= CH_NINE);
   endfunction

   function automatic void owe_line(input int unsigned n);
      for (int unsigned k = 0; k < n; k++) begin
         owed_beats.push_back('{ch: line_text[k], last: (k + 1 == n), len: n[LEN_W-1:0]});
      end
   endfunction

   task automatic absorb_req(input logic cmd, input logic [BYTE_W-1:0] rx);
      logic [CHAR_W-1:0] c;
      c = rx[CHAR_W-1:0];
      case (decode_req(cmd, rx))
         OP_FRAME_END: begin
            // hold a lone "A": its "T" may come in the next frame
            if (!(text_fill == 1 && line_text[0] == CH_A)) begin
               owe_line(text_fill);
               text_fill = 0;
            end
         end
         OP_EOL: begin
            owe_line(text_fill);
            text_fill = 0;
         end
         OP_BKSP: begin
            if (text_fill > 0) text_fill--;
         end
         OP_CHAR: begin
            if (c == CH_T && text_fill >= 2 && line_text[text_fill - 1] == CH_A &&
                !word_char(line_text[text_fill - 2])) begin
               // new command starts: emit what precedes the "A", keep "AT"
               owe_line(text_fill - 1);
               line_text[0] = CH_A;
               line_text[1] = CH_T;
               text_fill    = 2;
            end else if (text_fill < LINE_BYTES - 1) begin
               line_text[text_fill] = c;
               text_fill++;
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_beat();
      line_beat_type want;
      if (owed_beats.size() == 0) begin
         $error("line_char: expected no beat, got %h", rsp_line_char);
         mismatches++;
      end else begin
         want = owed_beats.pop_front();
         if (rsp_line_char !== want.ch) begin
            $error("line_char: expected %h, got %h", want.ch, rsp_line_char);
            mismatches++;
         end
         if (rsp_last_of_line !== want.last) begin
            $error("last_of_line: expected %b, got %b", want.last, rsp_last_of_line);
            mismatches++;
         end
         if (rsp_line_length !== want.len) begin
            $error("line_length: expected %0d, got %0d", want.len, rsp_line_length);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         text_fill  = 0;
         mismatches = 0;
         owed_beats.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_beat();
         if (req_valid && !req_stall) absorb_req(req_command, req_rx_byte);
      end
      chars_owed <= owed_beats.size();
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top: feeds byte and idle beats to the line assembler, stalls results, gives the verdict.
module tb_top;
   import acla_pkg::*;

   localparam int RAND_ITEMS      = 170;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT  = 3000;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   logic              req_command = 1'b0;
   logic [BYTE_W-1:0] req_rx_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b1;
   logic [CHAR_W-1:0] rsp_line_char;
   logic              rsp_last_of_line;
   logic [LEN_W-1:0]  rsp_line_length;

   int   mismatches;
   int   chars_owed;
   int   items_sent  = 0;
   int   beats_taken = 0;
   int   idle_cycles = 0;
   logic send_burst  = 1'b0;
   logic take_burst  = 1'b0;

   always #5 clock = ~clock;

   at_command_line_assembler i_dut (.*);

   line_assembly_checker i_checker (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] rx);
      int gap;
      if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      send_item(1'b0, rx);
   endtask

   // rx_byte is junk on an idle beat, so randomize it
   task automatic send_idle();
      send_item(1'b1, 8'($urandom_range(0, 255)));
   endtask

   function automatic logic [BYTE_W-1:0] pick_char();
      logic [BYTE_W-1:0] edge_chars [8] = '{" ", "0", "9", "Z", "@", "[", "/", ":"};
      case ($urandom_range(0, 7))
         0, 1: return "A";
         2: return "T";
         3: return edge_chars[$urandom_range(0, 7)];
         default: return 8'($urandom_range(PRINT_LO, PRINT_HI));
      endcase
   endfunction

   // printable text with no "T", so no split can shorten it
   task automatic send_filler(input int n);
      logic [BYTE_W-1:0] c;
      for (int k = 0; k < n; k++) begin
         c = 8'($urandom_range(PRINT_LO, PRINT_HI));
         if (c == "T") c = "t";
         send_byte(c);
      end
   endtask

   task automatic send_line_end();
      case ($urandom_range(0, 3))
         0: send_byte(BYTE_CR);
         1: send_byte(BYTE_LF);
         2: begin
            send_byte(BYTE_CR);
            send_byte(BYTE_LF);
         end
         default: send_idle();
      endcase
   endtask

   task automatic send_random_sequence();
      int n;
      n = $urandom_range(0, 12);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            send_byte("A");
            send_byte("T");
            repeat (n) send_byte(pick_char());
            send_line_end();
         end
         6: begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 3) == 0) send_idle();
               else send_byte(8'($urandom_range(0, 255)));
            end
         end
         7: begin
            send_byte("A");
            send_byte("T");
            repeat (n) begin
               if ($urandom_range(0, 2) == 0) send_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
               else send_byte(pick_char());
            end
            send_line_end();
         end
         8: begin
            // several commands in one frame, split apart by their "AT"
            repeat ($urandom_range(2, 3)) begin
               send_byte("A");
               send_byte("T");
               repeat ($urandom_range(0, 5)) send_byte(pick_char());
               if ($urandom_range(0, 1)) send_byte(";");
            end
            send_idle();
         end
         default: begin
            if ($urandom_range(0, 1)) send_byte("A");
            send_idle();
            if ($urandom_range(0, 1)) send_idle();
         end
      endcase
   endtask

   initial begin : result_taker
      int gap;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && beats_taken == 3) begin
            // hold off long enough for the queue to fill and stall the byte side
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if ($urandom_range(0, 15) == 0) take_burst = !take_burst;
         gap = take_burst ? 0 : $urandom_range(0, 15);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         beats_taken++;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle();                // empty line end on idle
      send_byte(BYTE_CR);         // and on CR
      send_byte("A");
      send_idle();                // lone "A" survives the idle
      send_byte("T");
      send_byte(BYTE_LF);
      send_byte(BYTE_BS);         // backspace on empty
      send_byte(BYTE_NUL);
      send_byte(PRINT_LO);
      send_byte(PRINT_HI);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h1F);
      send_byte(BYTE_DEL);
      send_byte("A");
      send_byte("T");             // split after a space
      send_byte("Z");
      send_byte("A");
      send_byte("T");             // no split after a letter
      send_byte("9");
      send_byte("A");
      send_byte("T");             // no split after a digit
      send_idle();

      send_filler(LINE_BYTES - 3);
      send_byte(" ");
      send_byte("A");
      send_byte("x");             // store full: drop
      send_byte("y");
      send_byte("T");             // split still taken with the store full
      send_filler(LINE_BYTES - 3);
      send_byte("~");
      send_byte(BYTE_CR);         // longest line
      while (items_sent < RAND_ITEMS) send_random_sequence();
      req_valid <= 1'b0;

      // let the checker count the last beat before looking at what is owed
      @(posedge clock);
      while (chars_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
